// File: sv/dosr_pkg.sv
// ----------------------------------------------------------------------------
// Disk obstacle stamp package
// Shared types, register indexes and defaults for the row span rasterizer.
// ----------------------------------------------------------------------------
package dosr_pkg;

   // default sizing
   localparam int MAP_CELLS_DEF  = 4096;
   localparam int MAX_RADIUS_DEF = 31;

   // configuration port address width (seven registers, 4-byte stride)
   localparam int CSR_AW = 5;

   // register indexes
   localparam logic [2:0] REG_ENABLE      = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
   localparam logic [2:0] REG_CELLS_PER_M = 3'd3;
   localparam logic [2:0] REG_MAP_WIDTH   = 3'd4;
   localparam logic [2:0] REG_MAP_HEIGHT  = 3'd5;
   localparam logic [2:0] REG_RADIUS      = 3'd6;

   // signed grid coordinate with headroom for +/- radius
   typedef logic signed [14:0] coord_type;

   typedef struct packed {
      logic               enable;
      logic signed [31:0] org_x;
      logic signed [31:0] org_y;
      logic [24:0]        cells_per_metre;
      logic [12:0]        map_width;
      logic [12:0]        map_height;
      logic [4:0]         rad_cells;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic mul_y;
      logic cell_x;
      logic cell_y;
      logic clip;
      logic emit_row;
      logic emit_single;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic last_row;
      logic out_free;
   } status_type;

endpackage

// File: sv/dosr_ifs.sv
// ----------------------------------------------------------------------------
// Disk obstacle stamp channels
// Valid/ready channels for obstacle points and row span results.
// ----------------------------------------------------------------------------
interface dosr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic [12:0]        win_min_x;
   logic [12:0]        win_min_y;
   logic [12:0]        win_max_x;
   logic [12:0]        win_max_y;

   modport source (output valid, point_x, point_y, win_min_x, win_min_y,
                   win_max_x, win_max_y, input ready);
   modport sink (input valid, point_x, point_y, win_min_x, win_min_y,
                 win_max_x, win_max_y, output ready);
endinterface

interface dosr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] row_y;
   logic [11:0] span_start_x;
   logic [11:0] span_end_x;
   logic        span_valid;
   logic        last;

   modport source (output valid, row_y, span_start_x, span_end_x, span_valid,
                   last, input ready);
   modport sink (input valid, row_y, span_start_x, span_end_x, span_valid,
                 last, output ready);
endinterface

// File: sv/dosr_csr.sv
// ----------------------------------------------------------------------------
// Disk obstacle stamp register file
// APB-style configuration registers with reset values and read back.
// ----------------------------------------------------------------------------
module dosr_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dosr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output dosr_pkg::cfg_type          cfg
);
   import dosr_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_AW-1:2];
   assign cfg    = cfg_ff;

   // write registers in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b1;
         cfg_ff.org_x           <= '0;
         cfg_ff.org_y           <= '0;
         cfg_ff.cells_per_metre <= 25'd1310720;
         cfg_ff.map_width       <= 13'd4096;
         cfg_ff.map_height      <= 13'd4096;
         cfg_ff.rad_cells       <= 5'd7;
      end else if (wr_en) begin
         case (idx)
            REG_ENABLE:      cfg_ff.enable          <= pwdata[0];
            REG_ORIGIN_X:    cfg_ff.org_x           <= pwdata;
            REG_ORIGIN_Y:    cfg_ff.org_y           <= pwdata;
            REG_CELLS_PER_M: cfg_ff.cells_per_metre <= pwdata[24:0];
            REG_MAP_WIDTH:   cfg_ff.map_width       <= pwdata[12:0];
            REG_MAP_HEIGHT:  cfg_ff.map_height      <= pwdata[12:0];
            REG_RADIUS:      cfg_ff.rad_cells       <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_ENABLE:      prdata = {31'd0, cfg_ff.enable};
         REG_ORIGIN_X:    prdata = cfg_ff.org_x;
         REG_ORIGIN_Y:    prdata = cfg_ff.org_y;
         REG_CELLS_PER_M: prdata = {7'd0, cfg_ff.cells_per_metre};
         REG_MAP_WIDTH:   prdata = {19'd0, cfg_ff.map_width};
         REG_MAP_HEIGHT:  prdata = {19'd0, cfg_ff.map_height};
         REG_RADIUS:      prdata = {27'd0, cfg_ff.rad_cells};
         default:         prdata = '0;
      endcase
   end

endmodule

// File: sv/dosr_ctrl.sv
// ----------------------------------------------------------------------------
// Disk obstacle stamp controller
// Sequences cell mapping, clipping and one row span per output slot.
// ----------------------------------------------------------------------------
module dosr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dosr_pkg::status_type status,
   output dosr_pkg::cmd_type    cmd
);
   import dosr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_X,
      S_MUL_Y,
      S_CELL_Y,
      S_CLIP,
      S_CHECK,
      S_ROWS,
      S_SINGLE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            cmd.mul_en = 1'b1;
            state_in   = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.mul_en = 1'b1;
            cmd.mul_y  = 1'b1;
            cmd.cell_x = 1'b1;
            state_in   = S_CELL_Y;
         end
         S_CELL_Y: begin
            cmd.cell_y = 1'b1;
            state_in   = S_CLIP;
         end
         S_CLIP: begin
            cmd.clip = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = status.reject ? S_SINGLE : S_ROWS;
         end
         S_ROWS: begin
            if (status.out_free) begin
               cmd.emit_row = 1'b1;
               if (status.last_row) state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted item always starts the x mapping
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MUL_X) else $error("accept did not start mapping");

   // results load only into a free output slot
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_row || cmd.emit_single) |-> status.out_free)
      else $error("result loaded into busy output");

endmodule

// File: sv/dosr_dp.sv
// ----------------------------------------------------------------------------
// Disk obstacle stamp datapath
// Shared Q16.16 cell multiplier, window clipping and the per-row span unit.
// ----------------------------------------------------------------------------
module dosr_dp #(
   parameter int MAP_CELLS  = dosr_pkg::MAP_CELLS_DEF,
   parameter int MAX_RADIUS = dosr_pkg::MAX_RADIUS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dosr_pkg::cfg_type    cfg,
   input  dosr_pkg::cmd_type    cmd,
   output dosr_pkg::status_type status,
   dosr_req_if.sink             req_ch,
   dosr_rsp_if.source           rsp_ch
);
   import dosr_pkg::*;

   localparam logic [12:0] MapClamp = 13'((MAP_CELLS < 8191) ? MAP_CELLS : 8191);
   localparam logic [4:0]  RadClamp = 5'(MAX_RADIUS);

   function automatic coord_type cmax(coord_type a, coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic coord_type cmin(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

   // latched item
   logic signed [31:0] px_ff, py_ff;
   logic [12:0]        wx0_ff, wy0_ff, wx1_ff, wy1_ff;

   // mapping
   logic signed [32:0] diff;
   logic [56:0]        prod_ff;
   logic               neg_ff;
   logic [12:0]        mw, mh, lim;
   logic [24:0]        cell_raw;
   logic               cell_off;
   logic [12:0]        cx_ff, cy_ff;
   logic               offx_ff, offy_ff;
   logic [4:0]         rad;

   // clipped ranges
   coord_type  sx_ff, ex_ff, y_ff, ey_ff;
   logic [9:0] rr_ff;

   // row unit
   coord_type  cxs, dy, lo, hi;
   logic [4:0] dya, h;
   logic [9:0] dy2, rem;
   logic       rem_neg, row_ok;

   // output register
   logic        rsp_valid_ff;
   logic [11:0] row_ff, start_ff, end_ff;
   logic        span_ff, last_ff;

   assign mw  = (cfg.map_width > MapClamp) ? MapClamp : cfg.map_width;
   assign mh  = (cfg.map_height > MapClamp) ? MapClamp : cfg.map_height;
   assign rad = (cfg.rad_cells > RadClamp) ? RadClamp : cfg.rad_cells;

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff  <= req_ch.point_x;
         py_ff  <= req_ch.point_y;
         wx0_ff <= req_ch.win_min_x;
         wy0_ff <= req_ch.win_min_y;
         wx1_ff <= req_ch.win_max_x;
         wy1_ff <= req_ch.win_max_y;
      end
   end

   // offset from origin, then one registered multiply per axis
   assign diff = cmd.mul_y
      ? ($signed({py_ff[31], py_ff}) - $signed({cfg.org_y[31], cfg.org_y}))
      : ($signed({px_ff[31], px_ff}) - $signed({cfg.org_x[31], cfg.org_x}));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= 57'(diff[31:0]) * 57'(cfg.cells_per_metre);
         neg_ff  <= diff[32];
      end
   end

   // floor to cell and test against the map size
   assign cell_raw = prod_ff[56:32];
   assign lim      = cmd.cell_y ? mh : mw;
   assign cell_off = neg_ff || (cell_raw >= {12'd0, lim});

   always_ff @(posedge clock) begin
      if (cmd.cell_x) begin
         cx_ff   <= cell_raw[12:0];
         offx_ff <= cell_off;
      end
      if (cmd.cell_y) begin
         cy_ff   <= cell_raw[12:0];
         offy_ff <= cell_off;
      end
   end

   // clip the disk box to window and map, half open
   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         sx_ff <= cmax($signed({2'b00, cx_ff}) - $signed({10'd0, rad}),
                       $signed({2'b00, wx0_ff}));
         ex_ff <= cmin(cmin($signed({2'b00, cx_ff}) + $signed({10'd0, rad}),
                            $signed({2'b00, wx1_ff})), $signed({2'b00, mw}));
         ey_ff <= cmin(cmin($signed({2'b00, cy_ff}) + $signed({10'd0, rad}),
                            $signed({2'b00, wy1_ff})), $signed({2'b00, mh}));
         rr_ff <= {5'd0, rad} * {5'd0, rad};
      end
   end

   // row counter: start at the clipped first row, advance per span
   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         y_ff <= cmax($signed({2'b00, cy_ff}) - $signed({10'd0, rad}),
                      $signed({2'b00, wy0_ff}));
      end else if (cmd.emit_row) begin
         y_ff <= y_ff + coord_type'(1);
      end
   end

   // half width of the disk on this row
   assign cxs     = $signed({2'b00, cx_ff});
   assign dy      = y_ff - $signed({2'b00, cy_ff});
   assign dya     = dy[14] ? 5'(-dy) : dy[4:0];
   assign dy2     = {5'd0, dya} * {5'd0, dya};
   assign rem_neg = dy2 > rr_ff;
   assign rem     = rr_ff - dy2;

   // largest k with k*k <= rem, picked by priority over constant squares
   always_comb begin
      h = '0;
      for (int k = 1; k < 32; k++) begin
         if (rem >= 10'(k * k)) h = 5'(k);
      end
   end

   assign lo     = cmax(cxs - $signed({10'd0, h}), sx_ff);
   assign hi     = cmin(cxs + $signed({10'd0, h}), ex_ff - coord_type'(1));
   assign row_ok = !rem_neg && (lo <= hi);

   // status for the controller
   assign status.reject   = !cfg.enable || offx_ff || offy_ff || (y_ff >= ey_ff);
   assign status.last_row = (y_ff == ey_ff - coord_type'(1));
   assign status.out_free = !rsp_valid_ff || rsp_ch.ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_row || cmd.emit_single) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_row) begin
         row_ff   <= y_ff[11:0];
         start_ff <= row_ok ? lo[11:0] : 12'd0;
         end_ff   <= row_ok ? hi[11:0] : 12'd0;
         span_ff  <= row_ok;
         last_ff  <= status.last_row;
      end else if (cmd.emit_single) begin
         row_ff   <= '0;
         start_ff <= '0;
         end_ff   <= '0;
         span_ff  <= 1'b0;
         last_ff  <= 1'b1;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.row_y        = row_ff;
   assign rsp_ch.span_start_x = start_ff;
   assign rsp_ch.span_end_x   = end_ff;
   assign rsp_ch.span_valid   = span_ff;
   assign rsp_ch.last         = last_ff;

   // spans are only emitted for rows inside the clipped range
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_row |-> (y_ff < ey_ff)) else $error("row beyond clipped range");

   // a marked span never runs backwards
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && span_ff) |-> (start_ff <= end_ff))
      else $error("span start after end");

endmodule

// File: sv/disk_obstacle_stamp_rows_unit.sv
// After accept, the multiply, cell, clip and check states run before the first result
// is registered. An item gives up to 62 row spans, one per cycle from the shared row unit
// while the output is free; a rejected item gives one result. Items are taken only in idle.
// The single 32x25 cell multiplier is shared by x and y, one axis per cycle.
// Reset (synchronous, active high) restores register defaults and empties the pipe.
// ----------------------------------------------------------------------------
// Disk obstacle stamp rows unit
// Maps an obstacle point to a grid cell and emits clipped disk row spans.
// ----------------------------------------------------------------------------
module disk_obstacle_stamp_rows_unit #(
   parameter int MAP_CELLS  = dosr_pkg::MAP_CELLS_DEF,
   parameter int MAX_RADIUS = dosr_pkg::MAX_RADIUS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dosr_req_if.sink                    req_ch,
   dosr_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dosr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import dosr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       ready;

   dosr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dosr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   // input handshake comes from the controller
   assign req_ch.ready = ready;

   dosr_dp #(
      .MAP_CELLS  (MAP_CELLS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
